// ===== sv/psvm_pkg.sv =====
package psvm_pkg;

  localparam int unsigned VoiceCountDef  = 32;
  localparam int unsigned SampleSlotsDef = 512;
  localparam int unsigned FrameWordsDef  = 65536;

  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IdW    = 9;
  localparam int unsigned ValW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned VolW   = 13;
  localparam int unsigned AgeW   = 64;

  localparam logic [VolW-1:0] VolReset = 13'd3277;
  localparam logic [VolW-1:0] VolUnity = 13'd4096;

  // Limiter datapath: magnitude in Q.24 below 3.0 fits in 26 bits.
  localparam int unsigned LimAW   = 26;
  localparam int unsigned LimSW   = 28;
  localparam int unsigned LimNW   = 30;
  localparam int unsigned LimDW   = 31;
  localparam int unsigned LimPW   = LimAW + LimNW;
  localparam int unsigned LimRW   = LimPW + 1;
  localparam int unsigned QuotW   = 17;
  localparam logic [LimAW-1:0] LimSat = 26'h300_0000;
  localparam logic [LimNW-1:0] Lim27N = 30'h1B00_0000;
  localparam logic [LimDW-1:0] Lim27D = 31'h1B00_0000;
  localparam logic [QuotW-1:0] MagMax = 17'h08000;
  localparam logic [QuotW-1:0] MagPos = 17'h07FFF;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_RENDER = 2'd2
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

endpackage

// ===== sv/psvm_ram.sv =====
module psvm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/polyphonic_sample_voice_mixer_core.sv =====
// Channel   Direction  Handshake               Beat
// in        input      in_valid_i / in_stall_o  opcode, sample_value, sample_id, gain, last_flag
// out       output     out_valid_o / out_stall_i status, assigned_id, mixed_frame, block_audible
// cfg       input      cfg_valid_i / cfg_ready_o master_volume
//
// One item is worked at a time. When every voice is busy, a play scans the voice
// memory for the oldest. A render walks the voice memory, then scales the sum and
// runs the limiter with its 17-step divider.
// Reset is asynchronous and needs no clearing pass. A result waits in the output
// register while the next beat is accepted; the block holds in its last cycle until
// the output register is free.
module polyphonic_sample_voice_mixer_core import psvm_pkg::*; #(
  parameter int unsigned VOICE_COUNT  = VoiceCountDef,
  parameter int unsigned SAMPLE_SLOTS = SampleSlotsDef,
  parameter int unsigned FRAME_WORDS  = FrameWordsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [ValW-1:0]  sample_value_i,
  input  logic [IdW-1:0]          sample_id_i,
  input  logic signed [GainW-1:0] gain_i,
  input  logic                    last_flag_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic [IdW-1:0]          assigned_id_o,
  output logic signed [ValW-1:0]  mixed_frame_o,
  output logic                    block_audible_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [VolW-1:0]         cfg_master_volume_i
);

  localparam int unsigned VIW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned SIW  = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam int unsigned SCW  = $clog2(SAMPLE_SLOTS + 1);
  localparam int unsigned FAW  = $clog2(FRAME_WORDS);
  localparam int unsigned LPW  = $clog2(FRAME_WORDS + 1);
  localparam int unsigned ACW  = 32 + VIW;
  localparam int unsigned SCLW = ACW + VolW + 1;
  localparam int unsigned MAW  = SCLW - 15;
  localparam int unsigned STW  = FAW + LPW;

  typedef struct packed {
    logic [IdW-1:0]          sid;
    logic [LPW-1:0]          pos;
    logic signed [GainW-1:0] gain;
    logic [AgeW-1:0]         age;
  } voice_t;

  localparam int unsigned VRW = $bits(voice_t);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_LOAD   = 18'h00002,
    S_PLAY   = 18'h00004,
    S_PSCAN  = 18'h00008,
    S_PWRITE = 18'h00010,
    S_RV_RD  = 18'h00020,
    S_RV_SMP = 18'h00040,
    S_RV_FRM = 18'h00080,
    S_RV_MUL = 18'h00100,
    S_SUM    = 18'h00200,
    S_SCALE  = 18'h00400,
    S_ABS    = 18'h00800,
    S_SQ     = 18'h01000,
    S_AN     = 18'h02000,
    S_NUM    = 18'h04000,
    S_DIV    = 18'h08000,
    S_FIN    = 18'h10000,
    S_DONE   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic signed [ValW-1:0]  val_q;
  logic [IdW-1:0]          id_q;
  logic signed [GainW-1:0] gain_q;
  logic                    last_q;
  logic [VolW-1:0]         vol_q;
  logic [SCW-1:0]          loaded_q;
  logic [LPW-1:0]          lp_q, lb_q;
  logic [VOICE_COUNT-1:0]  active_q;
  logic [AgeW-1:0]         age_cnt_q;
  logic                    seen_q;
  logic [VIW-1:0]          vidx_q, cmp_idx_q, slot_q;
  logic                    cmp_vld_q;
  logic [AgeW-1:0]         best_age_q;
  voice_t                  vrec_q;
  logic                    take_q;
  logic signed [31:0]      prod_q;
  logic signed [ACW-1:0]   acc_q;
  logic signed [SCLW-1:0]  scaled_q;
  logic [LimAW-1:0]        a_q;
  logic                    sat_q, neg_q;
  logic [LimSW-1:0]        sq_q;
  logic [LimPW-1:0]        an_q;
  logic [LimDW-1:0]        d_q;
  logic [LimRW-1:0]        rem_q, trial_q;
  logic [QuotW-1:0]        quot_q;
  logic [4:0]              bit_q;

  logic [StatW-1:0]        pend_status_q, out_status_q;
  logic [IdW-1:0]          pend_assigned_q, out_assigned_q;
  logic [ValW-1:0]         pend_mixed_q, out_mixed_q;
  logic                    pend_aud_q, out_aud_q;
  logic                    out_valid_q, out_valid_d;

  // Memory ports.
  logic                    fr_we;
  logic [FAW-1:0]          fr_raddr;
  logic [ValW-1:0]         fr_rdata;
  logic                    st_we;
  logic [STW-1:0]          st_wdata, st_rdata;
  logic [SIW-1:0]          st_raddr;
  logic                    vc_we;
  logic [VIW-1:0]          vc_waddr;
  voice_t                  vc_wdata, vc_rd;
  logic [VRW-1:0]          vc_rdata;

  psvm_ram #(.Width(ValW), .Depth(FRAME_WORDS)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (lp_q[FAW-1:0]),
    .wdata_i (val_q),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  psvm_ram #(.Width(STW), .Depth(SAMPLE_SLOTS)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (SIW'(loaded_q)),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  psvm_ram #(.Width(VRW), .Depth(VOICE_COUNT)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (vc_we),
    .waddr_i (vc_waddr),
    .wdata_i (vc_wdata),
    .raddr_i (vidx_q),
    .rdata_o (vc_rdata)
  );

  assign vc_rd = voice_t'(vc_rdata);

  // Load path.
  logic              tbl_full, mem_full;
  logic [LPW-1:0]    lp_inc;
  assign tbl_full = (loaded_q >= SCW'(SAMPLE_SLOTS));
  assign mem_full = (lp_q >= LPW'(FRAME_WORDS));
  assign lp_inc   = lp_q + LPW'(1);
  assign st_wdata = {lb_q[FAW-1:0], LPW'(lp_inc - lb_q)};

  // First free voice; the lowest index wins.
  logic           any_free;
  logic [VIW-1:0] free_idx;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        any_free = 1'b1;
        free_idx = VIW'(i);
      end
    end
  end

  // Render walk.
  logic [FAW-1:0] smp_start;
  logic [LPW-1:0] smp_len;
  logic [LPW:0]   frm_addr, pos_inc;
  logic           in_rng, sid_bad, vidx_last, new_active;
  assign smp_start  = st_rdata[STW-1:LPW];
  assign smp_len    = st_rdata[LPW-1:0];
  assign in_rng     = (vrec_q.pos < smp_len);
  assign frm_addr   = (LPW+1)'(smp_start) + (LPW+1)'(vrec_q.pos);
  assign pos_inc    = (LPW+1)'(vrec_q.pos) + (LPW+1)'(1);
  assign new_active = in_rng && (pos_inc < (LPW+1)'(smp_len));
  assign fr_raddr   = frm_addr[FAW-1:0];
  assign st_raddr   = SIW'(vc_rd.sid);
  assign sid_bad    = (32'(vc_rd.sid) >= SAMPLE_SLOTS);
  assign vidx_last  = (vidx_q == VIW'(VOICE_COUNT - 1));

  always_comb begin
    fr_we    = 1'b0;
    st_we    = 1'b0;
    vc_we    = 1'b0;
    vc_waddr = vidx_q;
    vc_wdata = vrec_q;
    if (state_q == S_LOAD && !tbl_full && !mem_full) begin
      fr_we = 1'b1;
      st_we = last_q;
    end
    if (state_q == S_PWRITE) begin
      vc_we         = 1'b1;
      vc_waddr      = slot_q;
      vc_wdata.sid  = id_q;
      vc_wdata.pos  = '0;
      vc_wdata.gain = gain_q;
      vc_wdata.age  = age_cnt_q + AgeW'(1);
    end
    if (state_q == S_RV_FRM && in_rng) begin
      vc_we        = 1'b1;
      vc_wdata.pos = pos_inc[LPW-1:0];
    end
  end

  // Limiter arithmetic.
  logic signed [SCLW-1:0] scale_prod;
  logic signed [VolW:0]   vol_s;
  logic [SCLW-1:0]        mag_full;
  logic [MAW-1:0]         a_full;
  logic [2*LimAW-1:0]     a_sq;
  logic [LimNW-1:0]       n_val;
  logic                   div_ge;
  logic [QuotW-1:0]       mag;
  logic [ValW-1:0]        y_val;
  logic                   seen_any;
  assign vol_s      = {1'b0, vol_q};
  assign scale_prod = acc_q * vol_s;
  assign mag_full   = scaled_q[SCLW-1] ? SCLW'(-scaled_q) : SCLW'(scaled_q);
  assign a_full     = mag_full[SCLW-1:15];
  assign a_sq       = a_q * a_q;
  assign n_val      = Lim27N + LimNW'(sq_q);
  assign div_ge     = (rem_q >= trial_q);
  assign mag        = sat_q ? MagMax : ((quot_q > MagMax) ? MagMax : quot_q);
  always_comb begin
    if (neg_q) begin
      y_val = ValW'(QuotW'(0) - mag);
    end else begin
      y_val = (mag > MagPos) ? ValW'(MagPos) : mag[ValW-1:0];
    end
  end
  assign seen_any = seen_q || (y_val != '0);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_LOAD:   state_d = S_LOAD;
            OP_PLAY:   state_d = S_PLAY;
            OP_RENDER: state_d = S_RV_RD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_LOAD:  state_d = S_DONE;
      S_PLAY: begin
        if (32'(id_q) >= 32'(loaded_q)) begin
          state_d = S_DONE;
        end else if (any_free) begin
          state_d = S_PWRITE;
        end else begin
          state_d = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (cmp_vld_q && cmp_idx_q == VIW'(VOICE_COUNT - 1)) begin
          state_d = S_PWRITE;
        end
      end
      S_PWRITE: state_d = S_DONE;
      S_RV_RD: begin
        if (active_q[vidx_q]) begin
          state_d = S_RV_SMP;
        end else if (vidx_last) begin
          state_d = S_SUM;
        end
      end
      S_RV_SMP: begin
        if (!sid_bad) begin
          state_d = S_RV_FRM;
        end else begin
          state_d = vidx_last ? S_SUM : S_RV_RD;
        end
      end
      S_RV_FRM: state_d = S_RV_MUL;
      S_RV_MUL: state_d = vidx_last ? S_SUM : S_RV_RD;
      S_SUM:    state_d = S_SCALE;
      S_SCALE:  state_d = S_ABS;
      S_ABS:    state_d = S_SQ;
      S_SQ:     state_d = S_AN;
      S_AN:     state_d = S_NUM;
      S_NUM:    state_d = S_DIV;
      S_DIV:    state_d = (bit_q == '0) ? S_FIN : S_DIV;
      S_FIN:    state_d = S_DONE;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vol_q       <= VolReset;
      loaded_q    <= '0;
      lp_q        <= '0;
      lb_q        <= '0;
      active_q    <= '0;
      age_cnt_q   <= '0;
      seen_q      <= 1'b0;
      vidx_q      <= '0;
      cmp_vld_q   <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        vol_q <= (cfg_master_volume_i > VolUnity) ? VolUnity : cfg_master_volume_i;
      end
      unique case (state_q)
        S_IDLE: begin
          vidx_q <= '0;
        end
        S_LOAD: begin
          if (!tbl_full) begin
            if (mem_full) begin
              if (last_q) begin
                lp_q <= lb_q;
              end
            end else begin
              lp_q <= lp_inc;
              if (last_q) begin
                loaded_q <= loaded_q + SCW'(1);
                lb_q     <= lp_inc;
              end
            end
          end
        end
        S_PLAY: begin
          vidx_q    <= '0;
          cmp_vld_q <= 1'b0;
        end
        S_PSCAN: begin
          cmp_vld_q <= 1'b1;
          if (!vidx_last) begin
            vidx_q <= vidx_q + VIW'(1);
          end
        end
        S_PWRITE: begin
          active_q[slot_q] <= 1'b1;
          age_cnt_q        <= age_cnt_q + AgeW'(1);
        end
        S_RV_RD: begin
          if (!active_q[vidx_q] && !vidx_last) begin
            vidx_q <= vidx_q + VIW'(1);
          end
        end
        S_RV_SMP: begin
          if (sid_bad) begin
            active_q[vidx_q] <= 1'b0;
            if (!vidx_last) begin
              vidx_q <= vidx_q + VIW'(1);
            end
          end
        end
        S_RV_FRM: begin
          active_q[vidx_q] <= new_active;
        end
        S_RV_MUL: begin
          if (!vidx_last) begin
            vidx_q <= vidx_q + VIW'(1);
          end
        end
        S_NUM: begin
          bit_q <= 5'(QuotW - 1);
        end
        S_DIV: begin
          bit_q <= bit_q - 5'd1;
        end
        S_FIN: begin
          seen_q <= last_q ? 1'b0 : seen_any;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        val_q           <= sample_value_i;
        id_q            <= sample_id_i;
        gain_q          <= gain_i;
        last_q          <= last_flag_i;
        acc_q           <= '0;
        prod_q          <= '0;
        pend_status_q   <= ST_OK;
        pend_assigned_q <= '0;
        pend_mixed_q    <= '0;
        pend_aud_q      <= 1'b0;
      end
      S_LOAD: begin
        if (tbl_full || mem_full) begin
          pend_status_q <= ST_FULL;
        end else if (last_q) begin
          pend_assigned_q <= IdW'(loaded_q);
        end
      end
      S_PLAY: begin
        slot_q <= free_idx;
        if (32'(id_q) >= 32'(loaded_q)) begin
          pend_status_q <= ST_BAD_ID;
        end
      end
      S_PSCAN: begin
        cmp_idx_q <= vidx_q;
        if (cmp_vld_q && (cmp_idx_q == '0 || vc_rd.age < best_age_q)) begin
          best_age_q <= vc_rd.age;
          slot_q     <= cmp_idx_q;
        end
      end
      S_RV_RD: begin
        acc_q  <= acc_q + ACW'(prod_q);
        prod_q <= '0;
      end
      S_RV_SMP: begin
        vrec_q <= vc_rd;
      end
      S_RV_FRM: begin
        take_q <= in_rng && (frm_addr < (LPW+1)'(FRAME_WORDS));
      end
      S_RV_MUL: begin
        prod_q <= take_q ? $signed(fr_rdata) * vrec_q.gain : 32'sd0;
      end
      S_SUM: begin
        acc_q <= acc_q + ACW'(prod_q);
      end
      S_SCALE: begin
        scaled_q <= scale_prod;
      end
      S_ABS: begin
        neg_q <= scaled_q[SCLW-1];
        sat_q <= (a_full >= MAW'(LimSat));
        a_q   <= a_full[LimAW-1:0];
      end
      S_SQ: begin
        sq_q <= a_sq[2*LimAW-1:24];
      end
      S_AN: begin
        an_q <= a_q * n_val;
        d_q  <= Lim27D + {sq_q, 3'b000} + LimDW'(sq_q);
      end
      S_NUM: begin
        rem_q   <= LimRW'(an_q) + LimRW'({d_q, 8'd0});
        trial_q <= LimRW'({d_q, 25'd0});
        quot_q  <= '0;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - trial_q;
        end
        trial_q <= trial_q >> 1;
        quot_q  <= {quot_q[QuotW-2:0], div_ge};
      end
      S_FIN: begin
        pend_mixed_q <= y_val;
        pend_aud_q   <= last_q && seen_any;
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q   <= pend_status_q;
          out_assigned_q <= pend_assigned_q;
          out_mixed_q    <= pend_mixed_q;
          out_aud_q      <= pend_aud_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign assigned_id_o   = out_assigned_q;
  assign mixed_frame_o   = out_mixed_q;
  assign block_audible_o = out_aud_q;

endmodule

// ===== sv/psvm_checker.sv =====
module psvm_checker import psvm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [OpW-1:0]          opcode_i,
  input logic signed [ValW-1:0]  sample_value_i,
  input logic [IdW-1:0]          sample_id_i,
  input logic signed [GainW-1:0] gain_i,
  input logic                    last_flag_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [StatW-1:0]        status_o,
  input logic [IdW-1:0]          assigned_id_o,
  input logic signed [ValW-1:0]  mixed_frame_o,
  input logic                    block_audible_o,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [VolW-1:0]         cfg_master_volume_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mixed_frame_o) && $stable(status_o))
    else $error("stalled result changed");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> mixed_frame_o == '0 && block_audible_o == 1'b0
      && assigned_id_o == '0)
    else $error("rejected item carries a payload");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an item is in work");

endmodule

bind polyphonic_sample_voice_mixer_core psvm_checker u_psvm_checker (.*);

// ===== bench/mixer_checker.sv =====
`timescale 1ns / 100ps
module mixer_checker import psvm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [ValW-1:0]  sample_value_i,
  input  logic [IdW-1:0]          sample_id_i,
  input  logic signed [GainW-1:0] gain_i,
  input  logic                    last_flag_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [StatW-1:0]        status_i,
  input  logic [IdW-1:0]          assigned_id_i,
  input  logic signed [ValW-1:0]  mixed_frame_i,
  input  logic                    block_audible_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [VolW-1:0]         cfg_master_volume_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    status_e                status;
    logic [IdW-1:0]         id;
    logic signed [ValW-1:0] frame;
    logic                   audible;
  } mix_result_t;

  localparam int NV = VoiceCountDef;

  logic signed [ValW-1:0] frame_mem [0:FrameWordsDef-1];
  int unsigned            smp_start [0:SampleSlotsDef-1];
  int unsigned            smp_len   [0:SampleSlotsDef-1];
  int unsigned            n_samples, wr_ptr, wr_begin, vol;
  bit                     v_on  [0:NV-1];
  int unsigned            v_smp [0:NV-1];
  int unsigned            v_pos [0:NV-1];
  int                     v_gain[0:NV-1];
  longint unsigned        v_age [0:NV-1];
  longint unsigned        age_now;
  bit                     heard;
  mix_result_t            expected_q[$];

  function automatic logic signed [ValW-1:0] soft_clip(longint scaled);
    longint unsigned m, a, s, n, d, mag;
    bit neg;
    neg = scaled < 0;
    m = neg ? longint'(-scaled) : longint'(scaled);
    a = m >> 15;
    if (a >= (64'd3 << 24)) begin
      mag = 32768;
    end else begin
      s = (a * a) >> 24;
      n = (64'd27 << 24) + s;
      d = (64'd27 << 24) + 9 * s;
      mag = (a * n + (d << 8)) / (d << 9);
      if (mag > 32768) mag = 32768;
    end
    if (neg) return ValW'(-longint'(mag));
    return (mag > 32767) ? 16'sd32767 : ValW'(mag);
  endfunction

  function automatic mix_result_t mix_beat(logic [OpW-1:0] op, logic signed [ValW-1:0] v,
                                           logic [IdW-1:0] id, logic signed [GainW-1:0] g,
                                           logic lst);
    mix_result_t r;
    int unsigned slot, p, len, addr;
    longint acc;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (n_samples >= SampleSlotsDef) begin
          r.status = ST_FULL;
        end else if (wr_ptr >= FrameWordsDef) begin
          r.status = ST_FULL;
          if (lst) wr_ptr = wr_begin;
        end else begin
          frame_mem[wr_ptr] = v;
          wr_ptr++;
          if (lst) begin
            smp_start[n_samples] = wr_begin;
            smp_len[n_samples] = wr_ptr - wr_begin;
            r.id = n_samples[IdW-1:0];
            n_samples++;
            wr_begin = wr_ptr;
          end
        end
      end
      OP_PLAY: begin
        if (id >= n_samples) begin
          r.status = ST_BAD_ID;
        end else begin
          // First idle voice wins; with all busy, the oldest one is taken over.
          slot = 0;
          for (int i = 0; i < NV; i++) begin
            if (!v_on[i]) begin
              slot = i;
              break;
            end
            if (v_age[i] < v_age[slot]) slot = i;
          end
          age_now++;
          v_smp[slot] = id;
          v_pos[slot] = 0;
          v_gain[slot] = g;
          v_age[slot] = age_now;
          v_on[slot] = 1'b1;
        end
      end
      OP_RENDER: begin
        acc = 0;
        for (int i = 0; i < NV; i++) begin
          if (v_on[i]) begin
            len = smp_len[v_smp[i]];
            p = v_pos[i];
            if (p < len) begin
              addr = smp_start[v_smp[i]] + p;
              if (addr < FrameWordsDef)
                acc += longint'(frame_mem[addr]) * longint'(v_gain[i]);
              p++;
              v_pos[i] = p;
            end
            v_on[i] = p < len;
          end
        end
        r.frame = soft_clip(acc * longint'(vol));
        if (r.frame != 0) heard = 1'b1;
        if (lst) begin
          r.audible = heard;
          heard = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t e;
    if (!rst_ni) begin
      n_samples = 0;
      wr_ptr = 0;
      wr_begin = 0;
      age_now = 0;
      heard = 1'b0;
      vol = VolReset;
      for (int i = 0; i < NV; i++) begin
        v_on[i] = 1'b0;
        v_age[i] = 0;
      end
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        vol = (cfg_master_volume_i > VolUnity) ? VolUnity : cfg_master_volume_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status_i);
            fail_count_o++;
          end
          if (assigned_id_i !== e.id) begin
            $error("assigned_id expected %0d actual %0d", e.id, assigned_id_i);
            fail_count_o++;
          end
          if (mixed_frame_i !== e.frame) begin
            $error("mixed_frame expected %0d actual %0d", e.frame, mixed_frame_i);
            fail_count_o++;
          end
          if (block_audible_i !== e.audible) begin
            $error("block_audible expected %0d actual %0d", e.audible, block_audible_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(mix_beat(opcode_i, sample_value_i, sample_id_i, gain_i,
                                      last_flag_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb import psvm_pkg::*;;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic [OpW-1:0]          opcode = '0;
  logic signed [ValW-1:0]  sample_value = '0;
  logic [IdW-1:0]          sample_id = '0;
  logic signed [GainW-1:0] gain = '0;
  logic                    last_flag = 1'b0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [VolW-1:0]         cfg_vol = '0;
  logic                    in_stall, out_valid, cfg_ready, block_audible;
  logic [StatW-1:0]        status;
  logic [IdW-1:0]          assigned_id;
  logic signed [ValW-1:0]  mixed_frame;
  int                      fails, pending;

  // Sender-side view of the sample table, only used to aim plays and fills.
  int unsigned ids_known = 0, fill_ptr = 0, fill_begin = 0;
  int unsigned n_items = 0, n_loads = 0, n_plays = 0, n_renders = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  always #5 clk = ~clk;

  polyphonic_sample_voice_mixer_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .sample_value_i(sample_value), .sample_id_i(sample_id),
    .gain_i(gain), .last_flag_i(last_flag),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .assigned_id_o(assigned_id), .mixed_frame_o(mixed_frame),
    .block_audible_o(block_audible),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_master_volume_i(cfg_vol)
  );

  mixer_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .sample_value_i(sample_value), .sample_id_i(sample_id),
    .gain_i(gain), .last_flag_i(last_flag),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .assigned_id_i(assigned_id), .mixed_frame_i(mixed_frame),
    .block_audible_i(block_audible),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_master_volume_i(cfg_vol),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        repeat (60) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic [OpW-1:0] op, input logic signed [ValW-1:0] v,
                           input logic [IdW-1:0] id, input logic signed [GainW-1:0] g,
                           input logic lst, input bit paced);
    if (paced && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    sample_value <= v;
    sample_id <= id;
    gain <= g;
    last_flag <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    case (op)
      OP_LOAD: begin
        n_loads++;
        if (ids_known < SampleSlotsDef) begin
          if (fill_ptr < FrameWordsDef) begin
            fill_ptr++;
            if (lst) begin
              ids_known++;
              fill_begin = fill_ptr;
            end
          end else if (lst) begin
            fill_ptr = fill_begin;
          end
        end
      end
      OP_PLAY:   n_plays++;
      OP_RENDER: n_renders++;
      default: ;
    endcase
  endtask

  // The first edge lets the checker count the beat accepted just before.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_volume(input logic [VolW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_vol <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beat;
    int unsigned r;
    logic [IdW-1:0] id;
    logic signed [GainW-1:0] g;
    r = $urandom_range(0, 99);
    g = $signed(GainW'($urandom)) >>> $urandom_range(0, 6);
    if (r < 28) begin
      send_beat(OP_LOAD, ValW'($urandom), IdW'($urandom), GainW'($urandom),
                $urandom_range(0, 5) == 0, 1'b1);
    end else if (r < 63) begin
      id = IdW'($urandom);
      if (ids_known > 0 && $urandom_range(0, 9) != 0) begin
        id = IdW'($urandom_range(0, ids_known - 1));
      end
      send_beat(OP_PLAY, ValW'($urandom), id, g, 1'($urandom), 1'b1);
    end else if (r < 95) begin
      send_beat(OP_RENDER, ValW'($urandom), IdW'($urandom), GainW'($urandom),
                $urandom_range(0, 7) == 0, 1'b1);
    end else if (r < 97 && ids_known > 0) begin
      // A run of plays that fills every voice and forces stealing.
      repeat (36)
        send_beat(OP_PLAY, '0, IdW'($urandom_range(0, ids_known - 1)),
                  $signed(GainW'($urandom)) >>> 3, 1'b0, 1'b1);
    end else begin
      send_beat(OpUnused, ValW'($urandom), IdW'($urandom), GainW'($urandom),
                1'($urandom), 1'b1);
    end
  endtask

  initial begin
    logic [VolW-1:0] vols [4];
    vols = '{13'd0, VolUnity, VolReset, 13'd1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_volume(13'h1FFF);
    send_beat(OP_PLAY,   '0, '0, 16'sd4096, 1'b0, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b1, 1'b0);
    send_beat(OP_LOAD,   16'sh7FFF, '0, '0, 1'b0, 1'b0);
    send_beat(OP_LOAD,   16'sh8000, '0, '0, 1'b0, 1'b0);
    send_beat(OP_LOAD,   16'sd0, '0, '0, 1'b1, 1'b0);
    send_beat(OP_LOAD,   16'sh7FFF, '0, '0, 1'b1, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd1, 16'sh7FFF, 1'b0, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd0, 16'sh8000, 1'b0, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd5, 16'sh7FFF, 1'b0, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd511, 16'sd1, 1'b1, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b0, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b0, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b1, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b1, 1'b0);
    send_beat(OpUnused, 16'shFFFF, 9'h1FF, 16'shFFFF, 1'b1, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd0, 16'sd1, 1'b0, 1'b0);
    send_beat(OP_PLAY,   '0, 9'd0, -16'sd1, 1'b0, 1'b0);
    send_beat(OP_RENDER, '0, '0, '0, 1'b1, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      set_volume(ph == 3 ? VolW'($urandom_range(0, 4096)) : vols[ph]);
      for (int k = 0; k < 100; k++) begin
        random_beat();
        if (ph == 1 && k == 50) begin
          hold_req = 1'b1;
          repeat (20) send_beat(OP_RENDER, '0, '0, '0, 1'b0, 1'b0);
        end
        if (ph == 2 && k == 50) drain();
      end
    end

    // Fill the sample table and knock on it once it is full.
    drain();
    quiet = 1'b1;
    while (ids_known < SampleSlotsDef)
      send_beat(OP_LOAD, ValW'($urandom), '0, '0, 1'b1, 1'b0);
    repeat (3) send_beat(OP_LOAD, ValW'($urandom), '0, '0, 1'b1, 1'b0);
    quiet = 1'b0;

    set_volume(VolW'($urandom_range(1000, 4096)));
    for (int k = 0; k < 200; k++) begin
      if (k == 150) quiet = 1'b1;
      random_beat();
    end
    drain();

    $display("Run covered %0d beats: %0d loads, %0d plays, %0d renders.",
             n_items, n_loads, n_plays, n_renders);
    $display("The sample table was driven to full, with volumes from 0 to unity.");
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/psvm_pkg.sv
sv/psvm_ram.sv
sv/polyphonic_sample_voice_mixer_core.sv
sv/psvm_checker.sv
bench/mixer_checker.sv
bench/tb.sv
